### design/hbf_pkg.sv
// Shared widths, constants and beat types of the harmonic bond force block.
package hbf_pkg;

  localparam int IDX_W           = 16;
  localparam int ATOM_INDEX_BITS = 16;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << ATOM_INDEX_BITS) - 64'd1);

  localparam int POS_W   = 32;
  localparam int D_W     = POS_W + 1;       // signed distance component
  localparam int UD_W    = D_W;             // its magnitude
  localparam int SQ_W    = 2 * UD_W;        // one square
  localparam int SUM_W   = 2 * UD_W;        // sum of three squares stays below 2^66
  localparam int LEN_W   = SUM_W / 2;
  localparam int REM_W   = LEN_W + 3;
  localparam int SQ_STAGES = LEN_W;
  localparam int K_W     = 32;
  localparam int S_W     = LEN_W + 1;       // signed stretch
  localparam int US_W    = LEN_W;           // stretch magnitude
  localparam int KU_W    = K_W + US_W;
  localparam int KU_LO_W = 32;
  localparam int KU_HI_W = KU_W - KU_LO_W;
  localparam int PL_W    = KU_LO_W + US_W;
  localparam int PH_W    = KU_HI_W + US_W;
  localparam int T_W     = PH_W + KU_LO_W;
  localparam int FRAC_W  = 16;
  localparam int DEN_W   = LEN_W + FRAC_W;
  localparam int QUO_W   = 32;
  localparam int DREM_W  = DEN_W + QUO_W;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int ENERGY_W = 48;
  localparam int E_SHIFT  = 2 * FRAC_W + 1; // Q16.16 squared, halved
  localparam logic [ENERGY_W-1:0] E_MAX = '1;
  localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             first;
    logic             last;
    logic [IDX_W-1:0] ai;
    logic [IDX_W-1:0] aj;
  } tag_t;

  typedef struct packed {
    tag_t                  tag;
    logic [2:0][UD_W-1:0]  ud;
    logic [2:0]            sgn;
    logic [K_W-1:0]        k;
    logic [K_W-1:0]        b0;
  } bond_t;

endpackage

### design/hbf_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module hbf_isqrt import hbf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] radicand,
  output logic [LEN_W-1:0] root
);

  logic [SUM_W-1:0] val_r  [SQ_STAGES];
  logic [REM_W-1:0] rem_r  [SQ_STAGES];
  logic [LEN_W-1:0] root_r [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    logic [SUM_W-1:0] v_in;
    logic [REM_W-1:0] r_in;
    logic [LEN_W-1:0] q_in;
    logic [REM_W-1:0] r_sh;
    logic [REM_W-1:0] test;
    logic [LEN_W-1:0] q_sh;
    logic [REM_W-1:0] rem_nxt;
    logic [LEN_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = val_r[j-1];
      assign r_in = rem_r[j-1];
      assign q_in = root_r[j-1];
    end

    always_comb begin
      r_sh = {r_in[REM_W-3:0], v_in[SUM_W-1 -: 2]};
      q_sh = {q_in[LEN_W-2:0], 1'b0};
      test = {{(REM_W-LEN_W-1){1'b0}}, q_sh, 1'b1};
      if (r_sh >= test) begin
        rem_nxt  = r_sh - test;
        root_nxt = q_sh | LEN_W'(1);
      end else begin
        rem_nxt  = r_sh;
        root_nxt = q_sh;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[j]  <= {v_in[SUM_W-3:0], 2'b00};
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];

endmodule

### design/hbf_div.sv
// Pipelined restoring divider, overflow check then one quotient bit per stage.
module hbf_div import hbf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [T_W-1:0]   num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [DREM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0]  den_r [DIV_STAGES];
  logic [QUO_W-1:0]  quo_r [DIV_STAGES];
  logic              ovf_r [DIV_STAGES];

  // quotient of 2^QUO_W or more saturates anyway
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (num >= T_W'({den, {QUO_W{1'b0}}}));
      rem_r[0] <= num[DREM_W-1:0];
      den_r[0] <= den;
      quo_r[0] <= '0;
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
    logic [DREM_W-1:0] test;
    logic [DREM_W-1:0] rem_nxt;
    logic [QUO_W-1:0]  quo_nxt;

    always_comb begin
      test = DREM_W'(den_r[j-1]) << (QUO_W - j);
      if (rem_r[j-1] >= test) begin
        rem_nxt = rem_r[j-1] - test;
        quo_nxt = quo_r[j-1] | (QUO_W'(1) << (QUO_W - j));
      end else begin
        rem_nxt = rem_r[j-1];
        quo_nxt = quo_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];

endmodule

### design/hbf_front.sv
// Front end: accept a bond beat, form the distance vector, push it to the queue.
module hbf_front import hbf_pkg::*; (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_first_bond,
  input  logic                    in_last_bond,
  input  logic [IDX_W-1:0]        in_atom_index_i,
  input  logic [IDX_W-1:0]        in_atom_index_j,
  input  logic signed [POS_W-1:0] in_pos_i_x,
  input  logic signed [POS_W-1:0] in_pos_i_y,
  input  logic signed [POS_W-1:0] in_pos_i_z,
  input  logic signed [POS_W-1:0] in_pos_j_x,
  input  logic signed [POS_W-1:0] in_pos_j_y,
  input  logic signed [POS_W-1:0] in_pos_j_z,
  input  logic [K_W-1:0]          in_spring_constant,
  input  logic [K_W-1:0]          in_rest_length,
  input  logic                    q_full,
  output logic                    push,
  output bond_t                   bond
);

  logic [2:0][POS_W-1:0] pi;
  logic [2:0][POS_W-1:0] pj;
  logic [2:0][D_W-1:0]   d;

  assign pi = {in_pos_i_z, in_pos_i_y, in_pos_i_x};
  assign pj = {in_pos_j_z, in_pos_j_y, in_pos_j_x};

  always_comb begin
    bond.tag.first = in_first_bond;
    bond.tag.last  = in_last_bond;
    bond.tag.ai    = in_atom_index_i & IDX_MASK;
    bond.tag.aj    = in_atom_index_j & IDX_MASK;
    bond.k         = in_spring_constant;
    bond.b0        = in_rest_length;
    for (int a = 0; a < 3; a++) begin
      d[a]        = {pj[a][POS_W-1], pj[a]} - {pi[a][POS_W-1], pi[a]};
      bond.sgn[a] = d[a][D_W-1];
      bond.ud[a]  = d[a][D_W-1] ? (~d[a] + UD_W'(1)) : d[a];
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

### design/hbf_queue.sv
// Short bond queue between the front end and the arithmetic pipeline.
module hbf_queue import hbf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  bond_t wdata,
  input  logic  pop,
  output bond_t rdata,
  output logic  full,
  output logic  not_empty
);

  bond_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

### design/hbf_back.sv
// Arithmetic pipeline: length, stretch, energy, force, running energy and result register.
module hbf_back import hbf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bond_t                      head,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_W-1:0]           out_atom_i,
  output logic [IDX_W-1:0]           out_atom_j,
  output logic signed [QUO_W-1:0]    out_force_x,
  output logic signed [QUO_W-1:0]    out_force_y,
  output logic signed [QUO_W-1:0]    out_force_z,
  output logic [ENERGY_W-1:0]        out_energy_total,
  output logic                       out_range_done,
  output logic                       out_zero_length
);

  typedef struct packed {
    tag_t                tag;
    logic [ENERGY_W-1:0] energy;
    logic                zl;
    logic [2:0]          fz;
    logic [2:0]          neg;
  } dv_side_t;

  logic adv;

  // stage 1: squares
  logic                  p1_v_r;
  bond_t                 p1_b_r;
  logic [2:0][SQ_W-1:0]  p1_sq_r;
  // stage 2: sum of squares
  logic                  p2_v_r;
  bond_t                 p2_b_r;
  logic [SUM_W-1:0]      p2_sum_r;
  // alongside the square root
  logic                  sd_v_r [SQ_STAGES];
  bond_t                 sd_b_r [SQ_STAGES];
  logic [LEN_W-1:0]      root;
  // stage 3: stretch
  logic [S_W-1:0]        s_diff;
  logic                  p3_v_r;
  bond_t                 p3_b_r;
  logic [LEN_W-1:0]      p3_len_r;
  logic [US_W-1:0]       p3_us_r;
  logic                  p3_sgn_r;
  logic                  p3_zl_r;
  // stage 4: k * |s|
  logic                  p4_v_r;
  tag_t                  p4_tag_r;
  logic [2:0][UD_W-1:0]  p4_ud_r;
  logic [LEN_W-1:0]      p4_len_r;
  logic [US_W-1:0]       p4_us_r;
  logic                  p4_zl_r;
  logic [2:0]            p4_fz_r;
  logic [2:0]            p4_neg_r;
  logic [KU_W-1:0]       p4_ku_r;
  // stage 5: partial products
  logic                  p5_v_r;
  tag_t                  p5_tag_r;
  logic [LEN_W-1:0]      p5_len_r;
  logic                  p5_zl_r;
  logic [2:0]            p5_fz_r;
  logic [2:0]            p5_neg_r;
  logic [PL_W-1:0]       p5_el_r;
  logic [PH_W-1:0]       p5_eh_r;
  logic [2:0][PL_W-1:0]  p5_fl_r;
  logic [2:0][PH_W-1:0]  p5_fh_r;
  // stage 6: full products
  logic                  p6_v_r;
  tag_t                  p6_tag_r;
  logic [DEN_W-1:0]      p6_den_r;
  logic                  p6_zl_r;
  logic [2:0]            p6_fz_r;
  logic [2:0]            p6_neg_r;
  logic [T_W-1:0]        p6_t_r;
  logic [2:0][T_W-1:0]   p6_n_r;
  // alongside the dividers
  logic [ENERGY_W-1:0]   energy;
  logic                  dd_v_r [DIV_STAGES];
  dv_side_t              dd_s_r [DIV_STAGES];
  logic [2:0][QUO_W-1:0] quo;
  logic [2:0]            ovf;
  // result
  dv_side_t              last_s;
  logic [2:0][QUO_W-1:0] force_v;
  logic [QUO_W-1:0]      lim;
  logic [QUO_W-1:0]      mag;
  logic [ENERGY_W-1:0]   e_base;
  logic [ENERGY_W:0]     e_add;
  logic [ENERGY_W-1:0]   esum_nxt;
  logic [ENERGY_W-1:0]   esum_r;
  logic                  out_valid_r;
  tag_t                  out_tag_r;
  logic [2:0][QUO_W-1:0] out_force_r;
  logic [ENERGY_W-1:0]   out_energy_r;
  logic                  out_zl_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      p5_v_r      <= 1'b0;
      p6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      esum_r      <= '0;
      for (int j = 0; j < SQ_STAGES; j++) begin
        sd_v_r[j] <= 1'b0;
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
        dd_v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      p1_v_r    <= head_valid;
      p2_v_r    <= p1_v_r;
      sd_v_r[0] <= p2_v_r;
      for (int j = 1; j < SQ_STAGES; j++) begin
        sd_v_r[j] <= sd_v_r[j-1];
      end
      p3_v_r    <= sd_v_r[SQ_STAGES-1];
      p4_v_r    <= p3_v_r;
      p5_v_r    <= p4_v_r;
      p6_v_r    <= p5_v_r;
      dd_v_r[0] <= p6_v_r;
      for (int j = 1; j < DIV_STAGES; j++) begin
        dd_v_r[j] <= dd_v_r[j-1];
      end
      out_valid_r <= dd_v_r[DIV_STAGES-1];
      if (dd_v_r[DIV_STAGES-1]) begin
        esum_r <= esum_nxt;
      end
    end
  end

  hbf_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (p2_sum_r),
    .root     (root)
  );

  assign s_diff = {1'b0, root} - {{(S_W-K_W){1'b0}}, sd_b_r[SQ_STAGES-1].b0};

  // energy from k*s^2, halved and saturated
  assign energy = (|p6_t_r[T_W-1:ENERGY_W+E_SHIFT]) ? E_MAX
                : p6_t_r[ENERGY_W+E_SHIFT-1:E_SHIFT];

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_b_r <= head;
      for (int a = 0; a < 3; a++) begin
        p1_sq_r[a] <= SQ_W'(head.ud[a]) * SQ_W'(head.ud[a]);
      end

      p2_b_r   <= p1_b_r;
      p2_sum_r <= SUM_W'(p1_sq_r[0]) + SUM_W'(p1_sq_r[1]) + SUM_W'(p1_sq_r[2]);

      sd_b_r[0] <= p2_b_r;
      for (int j = 1; j < SQ_STAGES; j++) begin
        sd_b_r[j] <= sd_b_r[j-1];
      end

      p3_b_r   <= sd_b_r[SQ_STAGES-1];
      p3_len_r <= root;
      p3_zl_r  <= (root == '0);
      p3_sgn_r <= s_diff[S_W-1];
      p3_us_r  <= s_diff[S_W-1] ? US_W'(~s_diff + S_W'(1)) : US_W'(s_diff);

      p4_tag_r <= p3_b_r.tag;
      p4_ud_r  <= p3_b_r.ud;
      p4_len_r <= p3_len_r;
      p4_us_r  <= p3_us_r;
      p4_zl_r  <= p3_zl_r;
      p4_ku_r  <= KU_W'(p3_b_r.k) * KU_W'(p3_us_r);
      for (int a = 0; a < 3; a++) begin
        p4_fz_r[a]  <= p3_zl_r || (p3_us_r == '0) || (p3_b_r.ud[a] == '0);
        p4_neg_r[a] <= p3_sgn_r ^ p3_b_r.sgn[a];
      end

      p5_tag_r <= p4_tag_r;
      p5_len_r <= p4_len_r;
      p5_zl_r  <= p4_zl_r;
      p5_fz_r  <= p4_fz_r;
      p5_neg_r <= p4_neg_r;
      p5_el_r  <= PL_W'(p4_ku_r[KU_LO_W-1:0]) * PL_W'(p4_us_r);
      p5_eh_r  <= PH_W'(p4_ku_r[KU_W-1:KU_LO_W]) * PH_W'(p4_us_r);
      for (int a = 0; a < 3; a++) begin
        p5_fl_r[a] <= PL_W'(p4_ku_r[KU_LO_W-1:0]) * PL_W'(p4_ud_r[a]);
        p5_fh_r[a] <= PH_W'(p4_ku_r[KU_W-1:KU_LO_W]) * PH_W'(p4_ud_r[a]);
      end

      p6_tag_r <= p5_tag_r;
      p6_den_r <= {p5_len_r, {FRAC_W{1'b0}}};
      p6_zl_r  <= p5_zl_r;
      p6_fz_r  <= p5_fz_r;
      p6_neg_r <= p5_neg_r;
      p6_t_r   <= T_W'(p5_el_r) + {p5_eh_r, {KU_LO_W{1'b0}}};
      for (int a = 0; a < 3; a++) begin
        p6_n_r[a] <= T_W'(p5_fl_r[a]) + {p5_fh_r[a], {KU_LO_W{1'b0}}};
      end

      dd_s_r[0].tag    <= p6_tag_r;
      dd_s_r[0].energy <= energy;
      dd_s_r[0].zl     <= p6_zl_r;
      dd_s_r[0].fz     <= p6_fz_r;
      dd_s_r[0].neg    <= p6_neg_r;
      for (int j = 1; j < DIV_STAGES; j++) begin
        dd_s_r[j] <= dd_s_r[j-1];
      end

      out_tag_r    <= last_s.tag;
      out_force_r  <= force_v;
      out_energy_r <= esum_nxt;
      out_zl_r     <= last_s.zl;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    hbf_div u_div (
      .clk (clk),
      .en  (adv),
      .num (p6_n_r[a]),
      .den (p6_den_r),
      .quo (quo[a]),
      .ovf (ovf[a])
    );
  end

  assign last_s = dd_s_r[DIV_STAGES-1];

  // saturate and sign each force component
  always_comb begin
    lim = '0;
    mag = '0;
    for (int a = 0; a < 3; a++) begin
      lim = last_s.neg[a] ? NEG_LIM : POS_LIM;
      mag = (ovf[a] || (quo[a] > lim)) ? lim : quo[a];
      if (last_s.fz[a]) begin
        force_v[a] = '0;
      end else if (last_s.neg[a]) begin
        force_v[a] = ~mag + QUO_W'(1);
      end else begin
        force_v[a] = mag;
      end
    end
  end

  // running energy, cleared by the first bond of a range, sticks at its maximum
  always_comb begin
    e_base   = last_s.tag.first ? '0 : esum_r;
    e_add    = {1'b0, e_base} + {1'b0, last_s.energy};
    esum_nxt = e_add[ENERGY_W] ? E_MAX : e_add[ENERGY_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_atom_i       = out_tag_r.ai;
  assign out_atom_j       = out_tag_r.aj;
  assign out_force_x      = out_force_r[0];
  assign out_force_y      = out_force_r[1];
  assign out_force_z      = out_force_r[2];
  assign out_energy_total = out_energy_r;
  assign out_range_done   = out_tag_r.last;
  assign out_zero_length  = out_zl_r;

endmodule

### design/harmonic_bond_force_top.sv
// Top level of the harmonic bond force block: front end, bond queue, arithmetic pipeline.
//
// Each input beat is one bond: two atom positions (signed Q16.16), a spring constant k and
// a rest length b0 (unsigned Q16.16). The block returns one result beat per bond, in order,
// holding the force on atom j (k*stretch*d/length, Q16.16, saturating), the running bond
// energy total (sum of 0.5*k*stretch^2, Q32.16, saturating; first_bond clears it before the
// bond is added) and flags for range end and coinciding atoms, which force zero force.
// Atom i takes the negated force downstream. The block takes one bond per clock cycle
// while the output is not stalled. Between acceptance and the result beat lie, in order,
// the queue write, two stages of squares and their sum, the pipelined square root (33
// stages, one root bit each), four stages of stretch and products, the three pipelined
// dividers (33 stages: an overflow check, then one quotient bit each) and the result
// register.
// A four-entry queue sits between the front end and the pipeline; in_stall rises only when
// that queue is full, and the whole pipeline holds while out_stall holds a waiting result.
module harmonic_bond_force_top import hbf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_first_bond,
  input  logic                    in_last_bond,
  input  logic [IDX_W-1:0]        in_atom_index_i,
  input  logic [IDX_W-1:0]        in_atom_index_j,
  input  logic signed [POS_W-1:0] in_pos_i_x,
  input  logic signed [POS_W-1:0] in_pos_i_y,
  input  logic signed [POS_W-1:0] in_pos_i_z,
  input  logic signed [POS_W-1:0] in_pos_j_x,
  input  logic signed [POS_W-1:0] in_pos_j_y,
  input  logic signed [POS_W-1:0] in_pos_j_z,
  input  logic [K_W-1:0]          in_spring_constant,
  input  logic [K_W-1:0]          in_rest_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_atom_i,
  output logic [IDX_W-1:0]        out_atom_j,
  output logic signed [QUO_W-1:0] out_force_x,
  output logic signed [QUO_W-1:0] out_force_y,
  output logic signed [QUO_W-1:0] out_force_z,
  output logic [ENERGY_W-1:0]     out_energy_total,
  output logic                    out_range_done,
  output logic                    out_zero_length
);

  logic  q_full;
  logic  q_not_empty;
  logic  push;
  logic  pop;
  bond_t bond_in;
  bond_t bond_head;

  // accept a beat when the queue has room, form the distance vector
  hbf_front u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_bond      (in_first_bond),
    .in_last_bond       (in_last_bond),
    .in_atom_index_i    (in_atom_index_i),
    .in_atom_index_j    (in_atom_index_j),
    .in_pos_i_x         (in_pos_i_x),
    .in_pos_i_y         (in_pos_i_y),
    .in_pos_i_z         (in_pos_i_z),
    .in_pos_j_x         (in_pos_j_x),
    .in_pos_j_y         (in_pos_j_y),
    .in_pos_j_z         (in_pos_j_z),
    .in_spring_constant (in_spring_constant),
    .in_rest_length     (in_rest_length),
    .q_full             (q_full),
    .push               (push),
    .bond               (bond_in)
  );

  // decouple intake from the arithmetic pipeline
  hbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (bond_in),
    .pop       (pop),
    .rdata     (bond_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // advance the pipeline whenever the result register is free or being taken
  hbf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (bond_head),
    .head_valid       (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_atom_i       (out_atom_i),
    .out_atom_j       (out_atom_j),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_force_z      (out_force_z),
    .out_energy_total (out_energy_total),
    .out_range_done   (out_range_done),
    .out_zero_length  (out_zero_length)
  );

endmodule
